/* rtl/lfr_pkg.sv */
// ============================================================================
// lfr_pkg - shared definitions for the letter frequency ranker
// Constants, letter decoding and the control bundles that pass between the
// sequencer, the bin store and the ranking scan unit.
// ============================================================================
package lfr_pkg;

    localparam int NUM_LETTERS     = 26;
    localparam int LETTER_W        = 5;
    localparam int OUT_COUNT_W     = 16;
    localparam int DEF_COUNT_WIDTH = 16;
    localparam int M_TDATA_W       = 24;

    localparam logic [7:0] CHAR_UPPER_A = 8'h41;
    localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
    localparam logic [7:0] CHAR_LOWER_A = 8'h61;
    localparam logic [7:0] CHAR_LOWER_Z = 8'h7A;

    localparam logic [LETTER_W-1:0] LAST_LETTER = LETTER_W'(NUM_LETTERS - 1);

    typedef struct packed {
        logic                hit;
        logic [LETTER_W-1:0] idx;
    } letter_dec_t;

    // Control of the bin store: increment the addressed bin, or clear them all.
    typedef struct packed {
        logic inc;
        logic clr;
    } bins_ctrl_t;

    // Control of the scan unit: start a new pass, or consider one bin.
    typedef struct packed {
        logic clear;
        logic step;
    } scan_ctrl_t;

    typedef enum logic [3:0] {
        ST_COUNT = 4'b0001,
        ST_SCAN  = 4'b0010,
        ST_EMIT  = 4'b0100,
        ST_EMPTY = 4'b1000
    } state_t;

    // Upper and lower case fold onto the same bin.
    function automatic letter_dec_t decode_letter(input logic [7:0] b);
        letter_dec_t d;
        d.hit = 1'b0;
        d.idx = '0;
        if (b >= CHAR_UPPER_A && b <= CHAR_UPPER_Z)
        begin
            d.hit = 1'b1;
            d.idx = LETTER_W'(b - CHAR_UPPER_A);
        end
        else if (b >= CHAR_LOWER_A && b <= CHAR_LOWER_Z)
        begin
            d.hit = 1'b1;
            d.idx = LETTER_W'(b - CHAR_LOWER_A);
        end
        return d;
    endfunction

endpackage

/* rtl/lfr_bins.sv */
// ============================================================================
// lfr_bins - histogram bin store
// Twenty-six saturating counters with one read address, a read-modify-write
// increment and a clear of all bins at once.
// ============================================================================
module lfr_bins #(
    parameter int COUNT_WIDTH = lfr_pkg::DEF_COUNT_WIDTH
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  lfr_pkg::bins_ctrl_t           ctrl,
    input  logic [lfr_pkg::LETTER_W-1:0]  addr,
    output logic [COUNT_WIDTH-1:0]        rd_cnt
);
    import lfr_pkg::*;

    logic [COUNT_WIDTH-1:0] bins_reg  [NUM_LETTERS];
    logic [COUNT_WIDTH-1:0] bins_next [NUM_LETTERS];

    assign rd_cnt = bins_reg[addr];

    always_comb
    begin
        bins_next = bins_reg;
        if (ctrl.clr)
        begin
            for (int i = 0; i < NUM_LETTERS; i++)
            begin
                bins_next[i] = '0;
            end
        end
        else if (ctrl.inc && !(&rd_cnt))
        begin
            // A full bin stays at its maximum.
            bins_next[addr] = rd_cnt + COUNT_WIDTH'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_LETTERS; i++)
            begin
                bins_reg[i] <= '0;
            end
        end
        else
        begin
            bins_reg <= bins_next;
        end
    end

endmodule

/* rtl/lfr_scan.sv */
// ============================================================================
// lfr_scan - ranking scan unit
// One comparator, stepped over the bins one per cycle while step is high,
// holds the largest count seen; a tie keeps the lowest letter (strict compare).
// ============================================================================
module lfr_scan #(
    parameter int COUNT_WIDTH = lfr_pkg::DEF_COUNT_WIDTH
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  lfr_pkg::scan_ctrl_t           ctrl,
    input  logic                          cand,
    input  logic [lfr_pkg::LETTER_W-1:0]  idx,
    input  logic [COUNT_WIDTH-1:0]        cnt,
    output logic [lfr_pkg::LETTER_W-1:0]  best_idx,
    output logic [COUNT_WIDTH-1:0]        best_cnt
);
    import lfr_pkg::*;

    logic                   found_reg,    found_next;
    logic [LETTER_W-1:0]    best_idx_reg, best_idx_next;
    logic [COUNT_WIDTH-1:0] best_cnt_reg, best_cnt_next;
    logic                   take;

    assign take = ctrl.step && cand && (!found_reg || (cnt > best_cnt_reg));

    always_comb
    begin
        found_next    = found_reg;
        best_idx_next = best_idx_reg;
        best_cnt_next = best_cnt_reg;
        if (ctrl.clear)
        begin
            found_next = 1'b0;
        end
        else if (take)
        begin
            found_next    = 1'b1;
            best_idx_next = idx;
            best_cnt_next = cnt;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            found_reg <= 1'b0;
        end
        else
        begin
            found_reg <= found_next;
        end
    end

    always_ff @(posedge clk)
    begin
        best_idx_reg <= best_idx_next;
        best_cnt_reg <= best_cnt_next;
    end

    assign best_idx = best_idx_reg;
    assign best_cnt = best_cnt_reg;

endmodule

/* rtl/letter_frequency_ranker.sv */
// ============================================================================
// letter_frequency_ranker - letter histogram of a text stream, ranked on demand
// Counts ASCII letters case-insensitively and, at the end of a text, emits
// the letters with a non-zero count in descending order of count.
// ============================================================================
// Usage:
// The slave channel carries one text byte per transfer in s_axis_tdata; a
// transfer with s_axis_tuser high marks the end of the text and its byte is
// ignored. While counting, the block takes one transfer every cycle, and a
// letter byte updates its bin in the same cycle.
// On an end transfer the block stops accepting and ranks the bins
// with one shared comparator: each result costs a full pass over the
// 26 bins, after which the result is loaded into the output register.
// A text with no letters gives a single result with valid_res low.
// Each result is held in an output register on the master channel; the last
// one carries m_axis_tlast. When the receiver stalls, the sequencer waits
// with the next result until the register is free. After the last result is
// loaded, the bins are cleared and counting resumes.
// Reset clears all bins, the letter mask and the output valid.
// ============================================================================
module letter_frequency_ranker #(
    parameter int COUNT_WIDTH = lfr_pkg::DEF_COUNT_WIDTH
) (
    input  logic                           clk,
    input  logic                           rst_n,
    // Slave channel
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    input  logic [7:0]                     s_axis_tdata,   // [7:0] text_byte
    input  logic                           s_axis_tuser,   // [0] end_of_text
    // Master channel
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    output logic [lfr_pkg::M_TDATA_W-1:0]  m_axis_tdata,   // [4:0] letter,
                                                           // [20:5] letter_count,
                                                           // [23:21] zero
    output logic                           m_axis_tuser,   // [0] valid_res
    output logic                           m_axis_tlast
);
    import lfr_pkg::*;

    state_t                  state_reg, state_next;
    logic [NUM_LETTERS-1:0]  mask_reg, mask_next;      // non-zero bins not yet ranked
    logic [LETTER_W-1:0]     scan_idx_reg, scan_idx_next;

    logic                    m_valid_reg, m_valid_next;
    logic [LETTER_W-1:0]     m_letter_reg, m_letter_next;
    logic [OUT_COUNT_W-1:0]  m_count_reg, m_count_next;
    logic                    m_res_reg, m_res_next;
    logic                    m_last_reg, m_last_next;

    logic                    s_accept;
    logic                    out_free;
    letter_dec_t             dec;
    bins_ctrl_t              bins_ctrl;
    scan_ctrl_t              scan_ctrl;
    logic [LETTER_W-1:0]     bin_addr;
    logic [COUNT_WIDTH-1:0]  bin_cnt;
    logic [LETTER_W-1:0]     best_idx;
    logic [COUNT_WIDTH-1:0]  best_cnt;
    logic [OUT_COUNT_W-1:0]  best_cnt_out;
    logic [NUM_LETTERS-1:0]  mask_left;

    assign s_axis_tready = (state_reg == ST_COUNT);
    assign s_accept      = s_axis_tvalid && s_axis_tready;
    assign out_free      = !m_valid_reg || m_axis_tready;
    assign dec           = decode_letter(s_axis_tdata);

    // The bin store has a single read port: the text byte's letter while
    // counting, the scan position while ranking.
    assign bin_addr  = (state_reg == ST_COUNT) ? dec.idx : scan_idx_reg;
    assign mask_left = mask_reg & ~(NUM_LETTERS'(1) << best_idx);

    // Counts wider than the result field report their saturated value.
    generate
        if (COUNT_WIDTH > OUT_COUNT_W)
        begin : g_wide
            assign best_cnt_out = (|best_cnt[COUNT_WIDTH-1:OUT_COUNT_W]) ?
                                  {OUT_COUNT_W{1'b1}} : best_cnt[OUT_COUNT_W-1:0];
        end
        else
        begin : g_narrow
            assign best_cnt_out = OUT_COUNT_W'(best_cnt);
        end
    endgenerate

    lfr_bins #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_bins (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctrl   (bins_ctrl),
        .addr   (bin_addr),
        .rd_cnt (bin_cnt)
    );

    lfr_scan #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_scan (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctrl     (scan_ctrl),
        .cand     (mask_reg[scan_idx_reg]),
        .idx      (scan_idx_reg),
        .cnt      (bin_cnt),
        .best_idx (best_idx),
        .best_cnt (best_cnt)
    );

    // Sequencer: count, then alternate scans and result loads, or an empty result.
    always_comb
    begin
        state_next    = state_reg;
        mask_next     = mask_reg;
        scan_idx_next = scan_idx_reg;
        bins_ctrl     = '0;
        scan_ctrl     = '0;
        m_valid_next  = m_valid_reg && !m_axis_tready;
        m_letter_next = m_letter_reg;
        m_count_next  = m_count_reg;
        m_res_next    = m_res_reg;
        m_last_next   = m_last_reg;

        unique case (state_reg)
            ST_COUNT:
            begin
                if (s_accept)
                begin
                    if (s_axis_tuser)
                    begin
                        if (mask_reg == '0)
                        begin
                            state_next = ST_EMPTY;
                        end
                        else
                        begin
                            state_next      = ST_SCAN;
                            scan_idx_next   = '0;
                            scan_ctrl.clear = 1'b1;
                        end
                    end
                    else if (dec.hit)
                    begin
                        bins_ctrl.inc      = 1'b1;
                        mask_next[dec.idx] = 1'b1;
                    end
                end
            end

            ST_SCAN:
            begin
                scan_ctrl.step = 1'b1;
                if (scan_idx_reg == LAST_LETTER)
                begin
                    state_next = ST_EMIT;
                end
                else
                begin
                    scan_idx_next = scan_idx_reg + LETTER_W'(1);
                end
            end

            ST_EMIT:
            begin
                if (out_free)
                begin
                    m_valid_next  = 1'b1;
                    m_letter_next = best_idx;
                    m_count_next  = best_cnt_out;
                    m_res_next    = 1'b1;
                    m_last_next   = (mask_left == '0);
                    mask_next     = mask_left;
                    if (mask_left == '0)
                    begin
                        bins_ctrl.clr = 1'b1;
                        state_next    = ST_COUNT;
                    end
                    else
                    begin
                        state_next      = ST_SCAN;
                        scan_idx_next   = '0;
                        scan_ctrl.clear = 1'b1;
                    end
                end
            end

            ST_EMPTY:
            begin
                if (out_free)
                begin
                    m_valid_next  = 1'b1;
                    m_letter_next = '0;
                    m_count_next  = '0;
                    m_res_next    = 1'b0;
                    m_last_next   = 1'b1;
                    state_next    = ST_COUNT;
                end
            end

            default:
            begin
                state_next = ST_COUNT;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_COUNT;
            mask_reg     <= '0;
            scan_idx_reg <= '0;
            m_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            mask_reg     <= mask_next;
            scan_idx_reg <= scan_idx_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        m_letter_reg <= m_letter_next;
        m_count_reg  <= m_count_next;
        m_res_reg    <= m_res_next;
        m_last_reg   <= m_last_next;
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = M_TDATA_W'({m_count_reg, m_letter_reg});
    assign m_axis_tuser  = m_res_reg;
    assign m_axis_tlast  = m_last_reg;

endmodule
